### src/y2r_pkg.sv
// Shared types and constants for the YUYV to RGB888 converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package y2r_pkg;

  // Fixed-point coefficient format and frame limits
  localparam int COEF_FRAC_BITS = 16;
  localparam int MAX_FRAME_DIM  = 4096;

  // Derived widths
  localparam int COEF_W = COEF_FRAC_BITS + 1;     // all coefficients are below 2.0
  localparam int PROD_W = COEF_W + 1 + 8;         // signed coef times signed chroma
  localparam int ACC_W  = COEF_FRAC_BITS + 11;    // Y*2^F plus two products, signed
  localparam int COL_W  = $clog2(MAX_FRAME_DIM / 2);
  localparam int LINE_W = $clog2(MAX_FRAME_DIM);
  localparam int DIM_W  = $clog2(MAX_FRAME_DIM) + 1;
  localparam int PAIR_W = COL_W + 1;              // pair count, holds MAX_FRAME_DIM/2
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 1;

  // BT.601 coefficients, rounded to nearest
  localparam logic [COEF_W-1:0] K_RV =
    COEF_W'(((64'd1402 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] K_GU =
    COEF_W'(((64'd344 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] K_GV =
    COEF_W'(((64'd714 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] K_BU =
    COEF_W'(((64'd1772 << COEF_FRAC_BITS) + 64'd500) / 64'd1000);

  // 255 in accumulator scale
  localparam logic signed [ACC_W-1:0] CHAN_TOP =
    ACC_W'(64'd255 << COEF_FRAC_BITS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Input beat: one YUYV macropixel
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_beat_t;

  // Output beat: two RGB888 pixels plus position markers
  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       end_of_line;
    logic       end_of_frame;
  } rgb_beat_t;

  // One converted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  // Shared chroma terms, computed once per macropixel
  typedef struct packed {
    logic signed [PROD_W-1:0] rv;
    logic signed [PROD_W-1:0] gu;
    logic signed [PROD_W-1:0] gv;
    logic signed [PROD_W-1:0] bu;
  } chroma_terms_t;

  // Position markers for one pair
  typedef struct packed {
    logic eol;
    logic eof;
  } pos_flags_t;

endpackage

### src/yuyv_to_rgb888_converter.sv
// Top level of the YUYV to RGB888 (BT.601) converter.
// Depends on y2r_pkg, y2r_lane and y2r_pos.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one YUYV macropixel
//   per beat: two luma samples sharing one Cb and one Cr.
//   Output channel (out_valid / out_stall / out_data) carries one beat per
//   input beat: two RGB888 pixels plus end_of_line / end_of_frame markers
//   from pair and line counters over the configured frame size.
//   cfg_we / cfg_index / cfg_data write frame_width (index 0) and
//   frame_height (index 1); writes leave the position counters alone.
// Pipeline: an accepted beat passes the stage 1 register, then the output
//   register; one beat per cycle while out_stall is low. The fully pipelined
//   chroma multiplier stage and two pixel lanes each have their own hand-off.
// Stall: when the receiver stalls, the output register holds; the
//   multiplier stage still takes one more beat if empty, then in_stall rises.
// Reset (rst_n low, synchronous): pipeline empties, counters go to the
//   frame start, frame size returns to 640 x 480.
`timescale 1ns / 1ps

module yuyv_to_rgb888_converter
  import y2r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  yuyv_beat_t           in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgb_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic          in_accept;
  logic          out_en;
  logic          s1_en;
  pos_flags_t    flags;

  logic          s1_valid_r, s1_valid_nxt;
  chroma_terms_t s1_terms_r;
  logic [7:0]    s1_luma0_r;
  logic [7:0]    s1_luma1_r;
  pos_flags_t    s1_flags_r;

  logic          out_valid_r, out_valid_nxt;
  rgb_beat_t     out_data_r;

  logic signed [7:0] cb_s;
  logic signed [7:0] cr_s;
  chroma_terms_t     terms;
  rgb_pixel_t        pix0;
  rgb_pixel_t        pix1;

  // Stage hand-off
  assign out_en    = !out_valid_r || !out_stall;
  assign s1_en     = !s1_valid_r || out_en;
  assign in_stall  = !s1_en;
  assign in_accept = in_valid && s1_en;

  // Position counters
  y2r_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .flags     (flags)
  );

  // Stage 1: remove chroma offset (flip MSB), shared chroma products
  assign cb_s = $signed({~in_data.chroma_blue[7], in_data.chroma_blue[6:0]});
  assign cr_s = $signed({~in_data.chroma_red[7], in_data.chroma_red[6:0]});

  always_comb begin
    terms.rv = PROD_W'($signed({1'b0, K_RV}) * cr_s);
    terms.gu = PROD_W'($signed({1'b0, K_GU}) * cb_s);
    terms.gv = PROD_W'($signed({1'b0, K_GV}) * cr_s);
    terms.bu = PROD_W'($signed({1'b0, K_BU}) * cb_s);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_en) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_terms_r <= terms;
      s1_luma0_r <= in_data.luma_first;
      s1_luma1_r <= in_data.luma_second;
      s1_flags_r <= flags;
    end
  end

  // Stage 2: two pixel lanes
  y2r_lane u_lane0 (
    .luma  (s1_luma0_r),
    .terms (s1_terms_r),
    .pixel (pix0)
  );

  y2r_lane u_lane1 (
    .luma  (s1_luma1_r),
    .terms (s1_terms_r),
    .pixel (pix1)
  );

  // Merge lanes and markers into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_en) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_data_r.red_first    <= pix0.red;
      out_data_r.green_first  <= pix0.green;
      out_data_r.blue_first   <= pix0.blue;
      out_data_r.red_second   <= pix1.red;
      out_data_r.green_second <= pix1.green;
      out_data_r.blue_second  <= pix1.blue;
      out_data_r.end_of_line  <= s1_flags_r.eol;
      out_data_r.end_of_frame <= s1_flags_r.eof;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/y2r_lane.sv
// One pixel lane: adds luma to the shared chroma terms, clamps each channel.
// Depends on y2r_pkg.
`timescale 1ns / 1ps

module y2r_lane
  import y2r_pkg::*;
(
  input  logic [7:0]    luma,
  input  chroma_terms_t terms,
  output rgb_pixel_t    pixel
);

  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_b;

  function automatic logic [7:0] clamp_floor(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc >= CHAN_TOP) begin
      res = 8'hFF;
    end else if (acc <= 0) begin
      res = 8'h00;
    end else begin
      res = acc[COEF_FRAC_BITS +: 8];
    end
    return res;
  endfunction

  // Luma scaled into accumulator format
  assign base = $signed(ACC_W'({luma, {COEF_FRAC_BITS{1'b0}}}));

  // Per-channel sums
  assign acc_r = base + ACC_W'(terms.rv);
  assign acc_g = base - ACC_W'(terms.gu) - ACC_W'(terms.gv);
  assign acc_b = base + ACC_W'(terms.bu);

  // Saturate and drop the fraction
  assign pixel.red   = clamp_floor(acc_r);
  assign pixel.green = clamp_floor(acc_g);
  assign pixel.blue  = clamp_floor(acc_b);

endmodule

### src/y2r_pos.sv
// Frame geometry registers and pair/line position counters.
// Depends on y2r_pkg.
`timescale 1ns / 1ps

module y2r_pos
  import y2r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  output pos_flags_t           flags
);

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;

  logic [DIM_W-1:0]  width_sat;
  logic [DIM_W-1:0]  height_sat;
  logic [PAIR_W-1:0] pairs;
  logic [COL_W-1:0]  last_col;
  logic [LINE_W-1:0] last_line;
  logic              col_end;
  logic              line_end;

  // Register writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate geometry and find the last pair and last line
  always_comb begin
    if (32'(width_r) > 32'(MAX_FRAME_DIM)) begin
      width_sat = DIM_W'(MAX_FRAME_DIM);
    end else begin
      width_sat = DIM_W'(width_r);
    end
    if (32'(height_r) > 32'(MAX_FRAME_DIM)) begin
      height_sat = DIM_W'(MAX_FRAME_DIM);
    end else begin
      height_sat = DIM_W'(height_r);
    end
    pairs = PAIR_W'(width_sat >> 1);
    if (pairs == '0) begin
      pairs = PAIR_W'(1);
    end
    if (height_sat == '0) begin
      height_sat = DIM_W'(1);
    end
    last_col  = COL_W'(pairs - PAIR_W'(1));
    last_line = LINE_W'(height_sat - DIM_W'(1));
  end

  // A counter at or past its last position ends the span
  assign col_end   = (col_r >= last_col);
  assign line_end  = (line_r >= last_line);
  assign flags.eol = col_end;
  assign flags.eof = col_end && line_end;

  // Counter advance on each accepted beat
  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        if (line_end) begin
          line_nxt = '0;
        end else begin
          line_nxt = line_r + LINE_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_WIDTH_RST;
      height_r <= FRAME_HEIGHT_RST;
      col_r    <= '0;
      line_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

### src/y2r_checker.sv
// Port-level checks for the YUYV to RGB888 converter, bound to the top level.
// Depends on y2r_pkg and yuyv_to_rgb888_converter.
`timescale 1ns / 1ps

module y2r_checker
  import y2r_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rgb_beat_t            out_data
);

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Input backpressure only comes from a stalled output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output beat");

  // An accepted beat reaches the output when the output beat ahead of it is not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid)
    else $error("accepted beat did not reach the output");

  // Stalled output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output beat dropped while stalled");

  // Stalled output payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("output payload changed while stalled");

endmodule

bind yuyv_to_rgb888_converter y2r_checker u_y2r_checker (.*);
